### rtl/core/sch_pkg.sv
package sch_pkg;

   // request payload layout
   localparam int LEAF_W    = 6;
   localparam int CLASS_W   = 4;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 32;
   localparam int CSR_W     = 5;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   localparam int LEAF_LSB  = 0;
   localparam int CLASS_LSB = LEAF_LSB + LEAF_W;
   localparam int FEAT_LSB  = CLASS_LSB + CLASS_W;
   localparam int THR_LSB   = FEAT_LSB + VALUE_W;

   localparam logic [CSR_W-1:0]   ACTIVE_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

   // request kinds carried in req_tuser
   localparam logic REQ_COUNT = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // rsp_tuser bit positions
   localparam int RSP_COUNTED_BIT = 0;
   localparam int RSP_BAD_BIT     = 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/core/sch_ctrl.sv
module sch_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  sch_pkg::dp_status_type status,
   output sch_pkg::ctrl_cmd_type  cmd
);
   import sch_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // write back and hand over once the result slot is free
            cmd.commit = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

### rtl/core/sch_datapath.sv
module sch_datapath #(
   parameter int LEAVES  = 64,
   parameter int CLASSES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sch_pkg::CSR_W-1:0]           csr_wr_data,
   input  logic                                req_tuser,
   input  logic [sch_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sch_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [sch_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  sch_pkg::ctrl_cmd_type               cmd,
   output sch_pkg::dp_status_type              status
);
   import sch_pkg::*;

   // only leaves and classes that the request fields can name are stored
   localparam int LEAVES_USED  = (LEAVES > 64) ? 64 : LEAVES;
   localparam int CLASSES_USED = (CLASSES > 16) ? 16 : CLASSES;
   localparam int LEAF_AW  = (LEAVES_USED > 1) ? $clog2(LEAVES_USED) : 1;
   localparam int CLASS_AW = (CLASSES_USED > 1) ? $clog2(CLASSES_USED) : 1;
   localparam int ADDR_W   = LEAF_AW + CLASS_AW;
   localparam int DEPTH    = 2 ** ADDR_W;

   logic [COUNT_W-1:0] mem [DEPTH];

   logic [CSR_W-1:0]   active_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               qualify_ff;
   logic               in_table_ff;
   logic               bad_ff;
   logic [COUNT_W-1:0] rd_data_ff;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_counted_ff;
   logic               rsp_bad_ff;

   logic [LEAF_W-1:0]        leaf;
   logic [CLASS_W-1:0]       cls;
   logic signed [VALUE_W-1:0] feat;
   logic signed [VALUE_W-1:0] thr;
   logic [ADDR_W-1:0]        req_addr;
   logic                     in_table;
   logic                     bad;
   logic                     qualify;
   logic [COUNT_W-1:0]       new_count;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [COUNT_W-1:0]       wr_data;

   assign leaf = req_tdata[LEAF_LSB +: LEAF_W];
   assign cls  = req_tdata[CLASS_LSB +: CLASS_W];
   assign feat = req_tdata[FEAT_LSB +: VALUE_W];
   assign thr  = req_tdata[THR_LSB +: VALUE_W];

   assign req_addr = {leaf[LEAF_AW-1:0], cls[CLASS_AW-1:0]};
   assign in_table = (32'(leaf) < 32'(LEAVES)) && (32'(cls) < 32'(CLASSES));
   // an active count above the table's class count acts as the class count
   assign bad      = (32'(cls) >= 32'(active_ff)) || (32'(cls) >= 32'(CLASSES));
   assign qualify  = (req_tuser == REQ_COUNT) && !bad && in_table && (feat <= thr);

   assign new_count = (qualify_ff && (rd_data_ff != COUNT_MAX)) ?
                      rd_data_ff + 1'b1 : rd_data_ff;

   assign wr_en   = cmd.clear_wr || (cmd.commit && qualify_ff);
   assign wr_addr = cmd.clear_wr ? clr_addr_ff : addr_ff;
   assign wr_data = cmd.clear_wr ? '0 : new_count;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.accept) begin
         rd_data_ff <= mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         if (cmd.clear_wr) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff     <= req_addr;
         qualify_ff  <= qualify;
         in_table_ff <= in_table;
         bad_ff      <= bad;
      end
      if (cmd.commit) begin
         rsp_count_ff   <= in_table_ff ? new_count : '0;
         rsp_counted_ff <= qualify_ff;
         rsp_bad_ff     <= bad_ff;
      end
   end

   assign status.clear_last = (clr_addr_ff == '1);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   always_comb begin
      rsp_tuser                  = '0;
      rsp_tuser[RSP_COUNTED_BIT] = rsp_counted_ff;
      rsp_tuser[RSP_BAD_BIT]     = rsp_bad_ff;
   end

endmodule

### rtl/core/split_class_histogram.sv
// Class histogram for decision tree splits: a table of 32-bit saturating counts, one per
// (leaf, class). A count request adds one to its leaf and class when the signed Q16.16
// feature is at or below the threshold and the class is below the active class count
// (csr_wr_data); a read request returns an entry. Each request is a memory read and then
// the write-back through the table's single write port, which waits until the previous
// response has been taken on rsp_tready. After reset the table is cleared one entry per
// cycle, all 1024 entries at the default size, and no request is taken until that ends.
module split_class_histogram #(
   parameter int LEAVES  = 64,
   parameter int CLASSES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [sch_pkg::CSR_W-1:0]          csr_wr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // leaf[5:0], class_label[9:6], feature_value[41:10], threshold[73:42], zero fill
   input  logic [sch_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // count
   output logic [sch_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // counted[0], bad_class[1]
   output logic [sch_pkg::RSP_USER_W-1:0]     rsp_tuser
);
   import sch_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   sch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sch_datapath #(
      .LEAVES  (LEAVES),
      .CLASSES (CLASSES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### sim/split_class_histogram_test.sv
`timescale 1ns / 1ps

module split_class_histogram_test;
   import sch_pkg::*;

   localparam int NUM_LEAVES     = 64;
   localparam int NUM_CLASSES    = 16;
   localparam int DIRECTED_N     = 23;
   localparam int CHUNKS         = 10;
   localparam int CHUNK_ITEMS    = 50;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_REPORTS    = 10;

   localparam logic [VALUE_W-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] Q_MAX = 32'h7fff_ffff;
   localparam logic [VALUE_W-1:0] Q_ONE = 32'h0001_0000;

   typedef struct packed {
      logic               kind;
      logic [LEAF_W-1:0]  leaf;
      logic [CLASS_W-1:0] cls;
      logic [VALUE_W-1:0] feature;
      logic [VALUE_W-1:0] threshold;
   } hist_req_t;

   typedef struct packed {
      logic               counted;
      logic [COUNT_W-1:0] count;
      logic               bad;
   } hist_rsp_t;

   typedef struct packed {
      bit             cfg_wr;
      logic [CSR_W-1:0] cfg_val;
      hist_req_t      rq;
      bit             typed;
      hist_rsp_t      rsp;
   } dir_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = REQ_COUNT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // predictor state
   logic [COUNT_W-1:0] leaf_class_count [NUM_LEAVES*NUM_CLASSES];
   logic [CSR_W-1:0]   active_classes_model = ACTIVE_RESET;
   hist_rsp_t          expected_tallies [$];

   int send_idle_pct = 24;
   int recv_idle_pct = 69;
   int mismatches = 0;
   int stall_cycles = 0;
   int requests_sent = 0;
   int results_seen = 0;
   int points_counted = 0;
   int bad_flags = 0;
   int cfg_writes = 0;

   dir_row_t directed_rows [DIRECTED_N] = '{
      '{1'b0, 5'd0,  '{REQ_READ,  6'd0,  4'd0,  32'd0, 32'd0}, 1'b1, '{1'b0, 32'd0, 1'b0}},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd0,  4'd0,  32'd0, 32'd0}, 1'b1, '{1'b1, 32'd1, 1'b0}},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd0,  4'd0,  Q_MIN, Q_MAX}, 1'b1, '{1'b1, 32'd2, 1'b0}},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd0,  4'd0,  Q_MAX, Q_MIN}, 1'b1, '{1'b0, 32'd2, 1'b0}},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd63, 4'd15, Q_MAX, Q_MAX}, 1'b1, '{1'b1, 32'd1, 1'b0}},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd63, 4'd15, Q_MIN, Q_MIN}, 1'b0, '0},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd63, 4'd15, Q_ONE, Q_ONE - 32'd1}, 1'b0, '0},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd5,  4'd7,  32'hffff_ffff, 32'd0}, 1'b0, '0},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd5,  4'd7,  32'd0, 32'hffff_ffff}, 1'b0, '0},
      '{1'b0, 5'd0,  '{REQ_READ,  6'd63, 4'd15, Q_MIN, 32'h1234_5678}, 1'b0, '0},
      '{1'b0, 5'd0,  '{REQ_READ,  6'd0,  4'd0,  Q_MAX, Q_MIN}, 1'b0, '0},
      '{1'b1, 5'd3,  '{REQ_COUNT, 6'd1,  4'd3,  32'd0, 32'd0}, 1'b1, '{1'b0, 32'd0, 1'b1}},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd1,  4'd2,  32'd0, 32'd0}, 1'b0, '0},
      '{1'b0, 5'd0,  '{REQ_READ,  6'd63, 4'd15, 32'd0, 32'd0}, 1'b0, '0},
      '{1'b1, 5'd0,  '{REQ_COUNT, 6'd2,  4'd0,  32'd0, 32'd0}, 1'b1, '{1'b0, 32'd0, 1'b1}},
      '{1'b0, 5'd0,  '{REQ_READ,  6'd0,  4'd0,  32'd0, 32'd0}, 1'b0, '0},
      '{1'b1, 5'd31, '{REQ_COUNT, 6'd63, 4'd15, -32'sd5, 32'd5}, 1'b0, '0},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd42, 4'd10, 32'd0, Q_ONE}, 1'b0, '0},
      '{1'b1, 5'd16, '{REQ_COUNT, 6'd21, 4'd5,  32'haaaa_aaaa, 32'h5555_5555}, 1'b0, '0},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd42, 4'd10, 32'h5555_5555, 32'haaaa_aaaa}, 1'b0, '0},
      '{1'b0, 5'd0,  '{REQ_READ,  6'd21, 4'd5,  32'd0, 32'd0}, 1'b0, '0},
      '{1'b1, 5'd1,  '{REQ_COUNT, 6'd0,  4'd0,  Q_ONE, Q_ONE}, 1'b0, '0},
      '{1'b0, 5'd0,  '{REQ_COUNT, 6'd0,  4'd1,  32'd0, 32'd0}, 1'b0, '0}
   };

   split_class_histogram #(
      .LEAVES  (NUM_LEAVES),
      .CLASSES (NUM_CLASSES)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // one tally step: updates the table copy and returns the response it causes
   function automatic hist_rsp_t tally_request(input hist_req_t rq);
      hist_rsp_t  r;
      int         eff_classes;
      int         idx;
      eff_classes = (active_classes_model > NUM_CLASSES) ? NUM_CLASSES
                                                          : int'(active_classes_model);
      idx = int'(rq.leaf) * NUM_CLASSES + int'(rq.cls);
      r.bad = (int'(rq.cls) >= eff_classes);
      r.counted = (rq.kind == REQ_COUNT) && !r.bad &&
                  ($signed(rq.feature) <= $signed(rq.threshold));
      if (r.counted && leaf_class_count[idx] != '1) begin
         leaf_class_count[idx] = leaf_class_count[idx] + 1'b1;
      end
      r.count = leaf_class_count[idx];
      return r;
   endfunction

   task automatic push_request(input hist_req_t rq, input bit typed, input hist_rsp_t typed_rsp);
      logic [REQ_DATA_W-1:0] word;
      hist_rsp_t             predicted;
      word = '0;
      word[LEAF_LSB +: LEAF_W]   = rq.leaf;
      word[CLASS_LSB +: CLASS_W] = rq.cls;
      word[FEAT_LSB +: VALUE_W]  = rq.feature;
      word[THR_LSB +: VALUE_W]   = rq.threshold;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= rq.kind;
      do @(posedge clock); while (!req_tready);
      predicted = tally_request(rq);
      expected_tallies.push_back(typed ? typed_rsp : predicted);
      requests_sent++;
   endtask

   // register writes only once every outstanding request has been answered
   task automatic write_active(input logic [CSR_W-1:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_tallies.size() != 0);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_classes_model = value;
      cfg_writes++;
   endtask

   always @(posedge clock) begin : rsp_check
      hist_rsp_t want;
      hist_rsp_t got;
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (rsp_tvalid && rsp_tready) begin
         got.counted = rsp_tuser[RSP_COUNTED_BIT];
         got.bad     = rsp_tuser[RSP_BAD_BIT];
         got.count   = rsp_tdata;
         results_seen++;
         if (got.counted) points_counted++;
         if (got.bad) bad_flags++;
         if (expected_tallies.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: counted %0b count %0d bad %0b",
                        got.counted, got.count, got.bad);
         end else begin
            want = expected_tallies.pop_front();
            if (got.counted !== want.counted || got.count !== want.count ||
                got.bad !== want.bad) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("response %0d mismatch: counted %0b/%0b count %0d/%0d bad %0b/%0b",
                           results_seen, want.counted, got.counted, want.count, got.count,
                           want.bad, got.bad);
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses pending",
                  stall_cycles, expected_tallies.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      hist_req_t        rq;
      logic [CSR_W-1:0] cfg_val;
      for (int i = 0; i < NUM_LEAVES * NUM_CLASSES; i++) leaf_class_count[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg_wr) write_active(directed_rows[i].cfg_val);
         push_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].rsp);
      end

      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         if (chunk < 4) begin
            send_idle_pct = 24;
            recv_idle_pct = 69;
         end else if (chunk < 7) begin
            send_idle_pct = 69;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (chunk)
            0: cfg_val = 5'd16;
            1: cfg_val = 5'd1;
            2: cfg_val = 5'd31;
            3: cfg_val = 5'd0;
            4: cfg_val = CSR_W'($urandom_range(15, 2));
            6: cfg_val = CSR_W'($urandom_range(30, 17));
            7: cfg_val = CSR_W'($urandom_range(31));
            8: cfg_val = 5'd8;
            default: cfg_val = 5'd16;
         endcase
         write_active(cfg_val);
         for (int n = 0; n < CHUNK_ITEMS; n++) begin
            rq.kind = ($urandom_range(99) < 30) ? REQ_READ : REQ_COUNT;
            // a few hot leaves so counts build up and back-to-back updates collide
            rq.leaf = ($urandom_range(3) == 0) ? LEAF_W'($urandom_range(63))
                                               : LEAF_W'($urandom_range(3));
            rq.cls  = CLASS_W'($urandom_range(15));
            rq.feature = $urandom;
            case ($urandom_range(4))
               0: rq.threshold = $urandom;
               1: rq.threshold = rq.feature;
               2: rq.threshold = rq.feature + 32'($urandom_range(2)) - 32'd1;
               3: begin
                  rq.feature   = $urandom_range(1) ? Q_MIN : Q_MAX;
                  rq.threshold = $urandom;
               end
               default: rq.threshold = $urandom_range(1) ? Q_MIN : Q_MAX;
            endcase
            push_request(rq, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_tallies.size() != 0);
      repeat (8) @(posedge clock);

      $display("covered %0d requests (%0d directed), %0d responses, %0d register writes",
               requests_sent, DIRECTED_N, results_seen, cfg_writes);
      $display("%0d points counted, %0d bad class flags, %0d mismatches",
               points_counted, bad_flags, mismatches);
      if (mismatches == 0 && expected_tallies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/sch_pkg.sv
rtl/core/sch_ctrl.sv
rtl/core/sch_datapath.sv
rtl/core/split_class_histogram.sv
sim/split_class_histogram_test.sv
